// ----- rtl/core/linear_rgb_to_oklab_defines.svh -----
// Assertion macros for the linear RGB to Oklab block.
`ifndef LINEAR_RGB_TO_OKLAB_DEFINES_SVH
`define LINEAR_RGB_TO_OKLAB_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define LRGBOK_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lrgbok: %m failed");
// Next-cycle implication.
`define LRGBOK_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lrgbok: %m failed");
`else
`define LRGBOK_ASSERT_IMP(label, clk, rst, ante, cons)
`define LRGBOK_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/lrgbok_pkg.sv -----
`timescale 1ns / 1ps
package lrgbok_pkg;

   localparam int DEF_INPUT_BITS  = 16;
   localparam int DEF_OUTPUT_BITS = 16;

   localparam int LANES = 3;

   // Q0.30 normalized component (up to 1.0) and Q0.20 cube root (up to 1.0)
   localparam int NORM_W = 31;
   localparam int ROOT_W = 21;
   typedef logic [NORM_W-1:0] unorm_type;
   typedef logic [ROOT_W-1:0] root_type;

   localparam int NORM_LAT   = 2;
   localparam int LANE_LAT   = 5;
   localparam int CBRT_STEPS = 21;
   localparam int MERGE_LAT  = 6;

   // coefficients scaled by 1e10
   localparam int LMS_COEF_W = 33;
   localparam int LAB_COEF_W = 36;

   localparam logic [LMS_COEF_W-1:0] LMS_COEF [LANES][LANES] = '{
      '{33'd4122214708, 33'd5363325363, 33'd514459929},
      '{33'd2119034982, 33'd6806995451, 33'd1073969566},
      '{33'd883024619,  33'd2817188376, 33'd6299787005}
   };

   localparam logic signed [LAB_COEF_W-1:0] LAB_COEF [LANES][LANES] = '{
      '{36'sd2104542553,   36'sd7936177850,  -36'sd40720468},
      '{36'sd19779984951, -36'sd24285922050,  36'sd4505937099},
      '{36'sd259040371,    36'sd7827717662,  -36'sd8086757660}
   };

   // 1e10 = 5^10 * 2^10; division by 5^10 is a reciprocal multiply
   localparam int DEC_W = 24;
   localparam logic [DEC_W-1:0] DEC5 = 24'd9765625;
   localparam int LMS_SHIFT = 10;
   localparam logic [63:0] LMS_HALF = 64'd5000000000;

   // q ~ ((n >> RCP_PRE) * RCP_DEC5) >> RCP_POST, low by at most one
   localparam int RCP_W    = 33;
   localparam int RCP_PRE  = 22;
   localparam int RCP_POST = 34;
   localparam logic [63:0] RCP_DEC5 = (64'd1 << (RCP_PRE + RCP_POST)) / 64'd9765625;

endpackage

// ----- rtl/core/lrgbok_norm.sv -----
`timescale 1ns / 1ps
`include "linear_rgb_to_oklab_defines.svh"
module lrgbok_norm import lrgbok_pkg::*; #(
   parameter int INPUT_BITS = DEF_INPUT_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [INPUT_BITS-1:0] in_code,
   output logic                  out_valid,
   output unorm_type             out_norm
);

   // u = x*2^30/(2^N-1) rounded = A + floor((A + h)/d), A = x*2^(30-N)
   localparam int SCALE_SH = 30 - INPUT_BITS;
   localparam logic [31:0] DIVISOR = 32'((64'd1 << INPUT_BITS) - 64'd1);
   localparam logic [31:0] HALF    = DIVISOR >> 1;
   localparam logic [31:0] RCP     = 32'((64'd1 << 31) / ((64'd1 << INPUT_BITS) - 64'd1));

   logic [NORM_LAT-1:0] valid_ff;
   logic [30:0] base, frac_num;
   logic [62:0] prod_in, prod_ff;
   logic [30:0] base_ff, frac_ff;
   logic [31:0] est, rem, quo;
   unorm_type   norm_in, norm_ff;

   assign base     = 31'(in_code) << SCALE_SH;
   assign frac_num = base + 31'(HALF);
   assign prod_in  = 63'(frac_num) * 63'(RCP);

   // estimate is exact or one low
   assign est     = prod_ff[62:31];
   assign rem     = 32'(frac_ff) - (est << INPUT_BITS) + est;
   assign quo     = (rem >= DIVISOR) ? est + 32'd1 : est;
   assign norm_in = base_ff + 31'(quo);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[NORM_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      base_ff <= base;
      frac_ff <= frac_num;
      norm_ff <= norm_in;
   end

   assign out_valid = valid_ff[NORM_LAT-1];
   assign out_norm  = norm_ff;

   `LRGBOK_ASSERT_IMP(a_norm_rem, clock, reset, valid_ff[0], rem < (DIVISOR << 1))

endmodule

// ----- rtl/core/lrgbok_cbrt.sv -----
`timescale 1ns / 1ps
module lrgbok_cbrt import lrgbok_pkg::*; (
   input  logic      clock,
   input  unorm_type in_rad,
   output root_type  out_root
);

   // floor(cbrt(v * 2^30)), one result digit per stage
   localparam int RAD_W = NORM_W + 30;
   localparam int SQ_W  = 2 * ROOT_W;
   localparam int B_W   = SQ_W + 2;

   logic [RAD_W-1:0] rad_ff [CBRT_STEPS-1];
   logic [SQ_W-1:0]  sq_ff  [CBRT_STEPS-1];
   root_type         y_ff   [CBRT_STEPS];

   for (genvar k = 0; k < CBRT_STEPS; k++) begin : g_step
      localparam int SH = 3 * (CBRT_STEPS - 1 - k);
      logic [RAD_W-1:0] rad_cur;
      root_type         y_cur, y2;
      logic [SQ_W-1:0]  sq_cur, sq2;
      logic [B_W-1:0]   tsum, trial;
      logic             take;

      if (k == 0) begin : g_first
         assign rad_cur = {in_rad, 30'd0};
         assign y_cur   = '0;
         assign sq_cur  = '0;
      end else begin : g_next
         assign rad_cur = rad_ff[k-1];
         assign y_cur   = y_ff[k-1];
         assign sq_cur  = sq_ff[k-1];
      end

      // trial = 3*y2^2 + 3*y2 + 1, with y2 = 2y and y^2 tracked
      assign y2    = y_cur << 1;
      assign sq2   = sq_cur << 2;
      assign tsum  = B_W'(sq2) + B_W'(y2);
      assign trial = tsum + (tsum << 1) + B_W'(1);
      assign take  = (rad_cur >> SH) >= RAD_W'(trial);

      always_ff @(posedge clock) begin
         y_ff[k] <= take ? y2 + ROOT_W'(1) : y2;
      end

      if (k < CBRT_STEPS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (take) begin
               rad_ff[k] <= rad_cur - (RAD_W'(trial) << SH);
               sq_ff[k]  <= sq2 + (SQ_W'(y2) << 1) + SQ_W'(1);
            end else begin
               rad_ff[k] <= rad_cur;
               sq_ff[k]  <= sq2;
            end
         end
      end
   end

   assign out_root = y_ff[CBRT_STEPS-1];

endmodule

// ----- rtl/core/lrgbok_lane.sv -----
`timescale 1ns / 1ps
`include "linear_rgb_to_oklab_defines.svh"
module lrgbok_lane import lrgbok_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [LMS_COEF_W-1:0] in_coef [LANES],
   input  unorm_type             in_norm [LANES],
   output logic                  out_valid,
   output root_type              out_root
);

   localparam int VLEN  = LANE_LAT + CBRT_STEPS;
   localparam int NUM_W = 54;
   localparam int PRD_W = 32 + RCP_W;
   localparam int ED_W  = NORM_W + DEC_W;
   localparam logic [NORM_W-1:0] ONE_Q30 = NORM_W'(1) << 30;

   logic [VLEN-1:0]  valid_ff;
   logic [63:0]      prod_ff [LANES];
   logic [63:0]      sum;
   logic [NUM_W-1:0] num2_ff, num3_ff, num4_ff;
   logic [PRD_W-1:0] prd_ff;
   logic [NORM_W-1:0] est, est_ff, quo;
   logic [ED_W-1:0]  estd_ff;
   logic [NUM_W-1:0] diff;
   unorm_type        lms_in, lms_ff;

   // row dot product, rounded by 1e10 (shift by 2^10, then divide by 5^10)
   assign sum = prod_ff[0] + prod_ff[1] + prod_ff[2] + LMS_HALF;
   assign est = NORM_W'(prd_ff >> RCP_POST);
   assign diff = num4_ff - NUM_W'(estd_ff);
   assign quo  = (diff >= NUM_W'(DEC5)) ? est_ff + NORM_W'(1) : est_ff;
   assign lms_in = (quo > ONE_Q30) ? ONE_Q30 : quo;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[VLEN-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < LANES; j++) begin
         prod_ff[j] <= 64'(in_coef[j]) * 64'(in_norm[j]);
      end
      num2_ff <= NUM_W'(sum >> LMS_SHIFT);
      prd_ff  <= PRD_W'(num2_ff[NUM_W-1:RCP_PRE]) * PRD_W'(RCP_DEC5[RCP_W-1:0]);
      num3_ff <= num2_ff;
      est_ff  <= est;
      estd_ff <= ED_W'(est) * ED_W'(DEC5);
      num4_ff <= num3_ff;
      lms_ff  <= lms_in;
   end

   lrgbok_cbrt u_cbrt (
      .clock    (clock),
      .in_rad   (lms_ff),
      .out_root (out_root)
   );

   assign out_valid = valid_ff[VLEN-1];

   `LRGBOK_ASSERT_IMP(a_lane_est, clock, reset, valid_ff[3], diff < (NUM_W'(DEC5) << 1))

endmodule

// ----- rtl/core/lrgbok_merge.sv -----
`timescale 1ns / 1ps
`include "linear_rgb_to_oklab_defines.svh"
module lrgbok_merge import lrgbok_pkg::*; #(
   parameter int OUTPUT_BITS = DEF_OUTPUT_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  root_type                      in_root [LANES],
   output logic                          out_valid,
   output logic [OUTPUT_BITS-2:0]        out_lightness,
   output logic signed [OUTPUT_BITS-1:0] out_green_red,
   output logic signed [OUTPUT_BITS-1:0] out_blue_yellow
);

   localparam int OB    = OUTPUT_BITS;
   localparam int ACC_W = 58;
   localparam int SH    = 31 - OB;
   localparam int M_W   = ACC_W - SH;
   localparam int MH_W  = OB + 2;
   localparam int P_W   = MH_W + RCP_W;
   localparam int ED_W  = OB + DEC_W;
   localparam logic [ACC_W-1:0] HALF_DEN = ACC_W'(DEC5) << (SH - 1);
   localparam logic [63:0]      SAT_LIM  = 64'(DEC5) << (OB - 1);
   localparam logic signed [OB-1:0] TOP = {1'b0, {(OB-1){1'b1}}};
   localparam logic signed [OB-1:0] BOT = {1'b1, {(OB-1){1'b0}}};

   typedef struct packed {
      logic neg;
      logic sat;
   } flags_type;

   logic [MERGE_LAT-1:0]    valid_ff;
   logic signed [ACC_W-1:0] prod_ff [LANES][LANES];
   logic signed [ACC_W-1:0] acc_ff  [LANES];
   logic [M_W-1:0]          m3_ff [LANES], m4_ff [LANES], m5_ff [LANES];
   flags_type               f3_ff [LANES], f4_ff [LANES], f5_ff [LANES];
   logic [P_W-1:0]          p4_ff [LANES];
   logic [OB-1:0]           est5_ff [LANES];
   logic [ED_W-1:0]         estd5_ff [LANES];
   logic [M_W-1:0]          diff [LANES];
   logic [OB-1:0]           quo [LANES];
   logic                    est_ok;
   logic [OB-2:0]           light_ff;
   logic signed [OB-1:0]    gr_ff, by_ff;

   always_comb begin
      est_ok = 1'b1;
      for (int i = 0; i < LANES; i++) begin
         diff[i] = m5_ff[i] - M_W'(estd5_ff[i]);
         quo[i]  = (diff[i] >= M_W'(DEC5)) ? est5_ff[i] + OB'(1) : est5_ff[i];
         if (!f5_ff[i].sat && diff[i] >= (M_W'(DEC5) << 1)) begin
            est_ok = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[MERGE_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      logic [ACC_W-1:0] mag;
      logic [ACC_W-1:0] rsum;
      logic [M_W-1:0]   m_next;
      logic [OB-1:0]    est;
      for (int i = 0; i < LANES; i++) begin
         for (int j = 0; j < LANES; j++) begin
            prod_ff[i][j] <= ACC_W'(LAB_COEF[i][j]) * ACC_W'($signed({1'b0, in_root[j]}));
         end
         acc_ff[i] <= prod_ff[i][0] + prod_ff[i][1] + prod_ff[i][2];

         // magnitude, round half away from zero, drop the power-of-two part
         mag    = acc_ff[i][ACC_W-1] ? ACC_W'(-acc_ff[i]) : ACC_W'(acc_ff[i]);
         rsum   = mag + HALF_DEN;
         m_next = M_W'(rsum >> SH);
         m3_ff[i]     <= m_next;
         f3_ff[i].neg <= acc_ff[i][ACC_W-1];
         f3_ff[i].sat <= 64'(m_next) >= SAT_LIM;

         p4_ff[i] <= P_W'(MH_W'(m3_ff[i] >> RCP_PRE)) * P_W'(RCP_DEC5[RCP_W-1:0]);
         m4_ff[i] <= m3_ff[i];
         f4_ff[i] <= f3_ff[i];

         est = OB'(p4_ff[i] >> RCP_POST);
         est5_ff[i]  <= est;
         estd5_ff[i] <= ED_W'(est) * ED_W'(DEC5);
         m5_ff[i]    <= m4_ff[i];
         f5_ff[i]    <= f4_ff[i];
      end

      if (f5_ff[0].neg) begin
         light_ff <= '0;
      end else if (f5_ff[0].sat) begin
         light_ff <= '1;
      end else begin
         light_ff <= quo[0][OB-2:0];
      end

      if (f5_ff[1].sat) begin
         gr_ff <= f5_ff[1].neg ? BOT : TOP;
      end else begin
         gr_ff <= f5_ff[1].neg ? -$signed(quo[1]) : $signed(quo[1]);
      end

      if (f5_ff[2].sat) begin
         by_ff <= f5_ff[2].neg ? BOT : TOP;
      end else begin
         by_ff <= f5_ff[2].neg ? -$signed(quo[2]) : $signed(quo[2]);
      end
   end

   assign out_valid       = valid_ff[MERGE_LAT-1];
   assign out_lightness   = light_ff;
   assign out_green_red   = gr_ff;
   assign out_blue_yellow = by_ff;

   `LRGBOK_ASSERT_IMP(a_merge_est, clock, reset, valid_ff[4], est_ok)

endmodule

// ----- rtl/core/linear_rgb_to_oklab.sv -----
`timescale 1ns / 1ps
// Path from start to rsp_valid: normalize, LMS row, cube root, then the output stages.
// Throughput: one item per clock outside reset; the 21-stage digit-per-stage cube root
//   in each lane sets the latency, every stage is fully pipelined.
// Results are shown for exactly one cycle on rsp_valid; the receiver cannot stall.
// Reset (synchronous, active high) flushes all valid bits; busy is high only in reset.
`include "linear_rgb_to_oklab_defines.svh"
module linear_rgb_to_oklab import lrgbok_pkg::*; #(
   parameter int INPUT_BITS  = DEF_INPUT_BITS,
   parameter int OUTPUT_BITS = DEF_OUTPUT_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [INPUT_BITS-1:0]         req_red_linear,
   input  logic [INPUT_BITS-1:0]         req_green_linear,
   input  logic [INPUT_BITS-1:0]         req_blue_linear,
   output logic                          rsp_valid,
   output logic [OUTPUT_BITS-2:0]        rsp_lightness,
   output logic signed [OUTPUT_BITS-1:0] rsp_green_red_axis,
   output logic signed [OUTPUT_BITS-1:0] rsp_blue_yellow_axis
);

   localparam int LATENCY = NORM_LAT + LANE_LAT + CBRT_STEPS + MERGE_LAT;

   logic                  accept;
   logic [INPUT_BITS-1:0] code [LANES];
   logic [LANES-1:0]      norm_valid;
   unorm_type             norm_val [LANES];
   logic [LANES-1:0]      lane_valid;
   root_type              root [LANES];

   // The datapath never stalls; items are refused only while reset is held.
   assign busy   = reset;
   assign accept = start && !busy;

   assign code[0] = req_red_linear;
   assign code[1] = req_green_linear;
   assign code[2] = req_blue_linear;

   // Per-component normalization: x/(2^N-1) to Q0.30, rounded, via reciprocal multiply.
   for (genvar c = 0; c < LANES; c++) begin : g_norm
      lrgbok_norm #(
         .INPUT_BITS (INPUT_BITS)
      ) u_norm (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (accept),
         .in_code   (code[c]),
         .out_valid (norm_valid[c]),
         .out_norm  (norm_val[c])
      );
   end

   // One lane per LMS channel: matrix row, rounding by 1e10, clamp to 1.0, cube root.
   for (genvar r = 0; r < LANES; r++) begin : g_lane
      lrgbok_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (&norm_valid),
         .in_coef   (LMS_COEF[r]),
         .in_norm   (norm_val),
         .out_valid (lane_valid[r]),
         .out_root  (root[r])
      );
   end

   // Merge: second matrix over the three roots, round half away, saturate.
   lrgbok_merge #(
      .OUTPUT_BITS (OUTPUT_BITS)
   ) u_merge (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (&lane_valid),
      .in_root         (root),
      .out_valid       (rsp_valid),
      .out_lightness   (rsp_lightness),
      .out_green_red   (rsp_green_red_axis),
      .out_blue_yellow (rsp_blue_yellow_axis)
   );

   // Every accepted item comes out on rsp_valid, and every rsp_valid traces back to an accepted item.
   `LRGBOK_ASSERT_NXT(a_top_out, clock, reset, accept, ##(LATENCY-1) rsp_valid)
   `LRGBOK_ASSERT_IMP(a_top_src, clock, reset, rsp_valid, $past(accept, LATENCY))

endmodule

// ----- tb/oklab_checker.sv -----
`timescale 1ns / 1ps
module oklab_checker import lrgbok_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [15:0]         req_red_linear,
   input  logic [15:0]         req_green_linear,
   input  logic [15:0]         req_blue_linear,
   input  logic                rsp_valid,
   input  logic [14:0]         rsp_lightness,
   input  logic signed [15:0]  rsp_green_red_axis,
   input  logic signed [15:0]  rsp_blue_yellow_axis,
   output int                  fail_count,
   output int                  pixels_in_flight
);

   typedef struct packed {
      logic [14:0]        lightness;
      logic signed [15:0] green_red;
      logic signed [15:0] blue_yellow;
   } oklab_pixel_type;

   localparam longint unsigned IN_MAX = 64'd65535;
   localparam longint unsigned DEC    = 64'd10000000000;
   localparam longint unsigned ONE_Q  = 64'd1 << 30;
   localparam longint unsigned LAB_DEN = 64'd9765625 << 15;

   localparam longint unsigned LMS_K [3][3] = '{
      '{64'd4122214708, 64'd5363325363, 64'd514459929},
      '{64'd2119034982, 64'd6806995451, 64'd1073969566},
      '{64'd883024619,  64'd2817188376, 64'd6299787005}
   };
   localparam longint LAB_K [3][3] = '{
      '{64'sd2104542553,   64'sd7936177850,  -64'sd40720468},
      '{64'sd19779984951, -64'sd24285922050,  64'sd4505937099},
      '{64'sd259040371,    64'sd7827717662,  -64'sd8086757660}
   };

   oklab_pixel_type expected_pixels[$];

   // exact floor cube root, one binary digit per pass
   function automatic longint unsigned cube_root_floor(longint unsigned n);
      longint unsigned y, b;
      y = 0;
      for (int sh = 60; sh >= 0; sh -= 3) begin
         y = y << 1;
         b = 3 * y * (y + 1) + 1;
         if ((n >> sh) >= b) begin
            n = n - (b << sh);
            y = y + 1;
         end
      end
      return y;
   endfunction

   function automatic longint div_round_away(longint num);
      longint unsigned mag, q;
      mag = (num < 0) ? longint'(-num) : num;
      q = (mag + LAB_DEN / 2) / LAB_DEN;
      return (num < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic oklab_pixel_type convert_pixel(logic [15:0] r, logic [15:0] g,
                                                     logic [15:0] b);
      longint unsigned norm [3];
      longint unsigned root [3];
      longint unsigned acc, v;
      longint lab [3];
      longint sacc;
      oklab_pixel_type px;
      norm[0] = ((longint'(r) << 30) + IN_MAX / 2) / IN_MAX;
      norm[1] = ((longint'(g) << 30) + IN_MAX / 2) / IN_MAX;
      norm[2] = ((longint'(b) << 30) + IN_MAX / 2) / IN_MAX;
      for (int i = 0; i < 3; i++) begin
         acc = 0;
         for (int j = 0; j < 3; j++) acc += LMS_K[i][j] * norm[j];
         v = (acc + DEC / 2) / DEC;
         if (v > ONE_Q) v = ONE_Q;
         root[i] = cube_root_floor(v << 30);
      end
      for (int i = 0; i < 3; i++) begin
         sacc = 0;
         for (int j = 0; j < 3; j++) sacc += LAB_K[i][j] * longint'(root[j]);
         lab[i] = div_round_away(sacc);
      end
      // L saturates at both ends; a and b are Q1.15, saturated to -32768..32767
      if (lab[0] < 0) lab[0] = 0;
      if (lab[0] > 32767) lab[0] = 32767;
      for (int i = 1; i < 3; i++) begin
         if (lab[i] < -32768) lab[i] = -32768;
         if (lab[i] > 32767) lab[i] = 32767;
      end
      px.lightness   = lab[0][14:0];
      px.green_red   = lab[1][15:0];
      px.blue_yellow = lab[2][15:0];
      return px;
   endfunction

   initial fail_count = 0;
   assign pixels_in_flight = expected_pixels.size();

   always @(posedge clock) begin
      oklab_pixel_type want;
      if (!reset) begin
         if (start && !busy)
            expected_pixels.push_back(convert_pixel(req_red_linear, req_green_linear,
                                                    req_blue_linear));
         if (rsp_valid) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected pixel out: L=%0d a=%0d b=%0d", rsp_lightness,
                      rsp_green_red_axis, rsp_blue_yellow_axis);
               fail_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_lightness !== want.lightness) begin
                  $error("lightness: expected %0d, got %0d", want.lightness, rsp_lightness);
                  fail_count++;
               end
               if (rsp_green_red_axis !== want.green_red) begin
                  $error("green_red_axis: expected %0d, got %0d", want.green_red,
                         rsp_green_red_axis);
                  fail_count++;
               end
               if (rsp_blue_yellow_axis !== want.blue_yellow) begin
                  $error("blue_yellow_axis: expected %0d, got %0d", want.blue_yellow,
                         rsp_blue_yellow_axis);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [15:0]        req_red_linear = '0;
   logic [15:0]        req_green_linear = '0;
   logic [15:0]        req_blue_linear = '0;
   logic               rsp_valid;
   logic [14:0]        rsp_lightness;
   logic signed [15:0] rsp_green_red_axis;
   logic signed [15:0] rsp_blue_yellow_axis;
   int                 fail_count;
   int                 pixels_in_flight;

   // 4 ns period
   always #2 clock = ~clock;

   linear_rgb_to_oklab DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_red_linear(req_red_linear), .req_green_linear(req_green_linear),
      .req_blue_linear(req_blue_linear), .rsp_valid(rsp_valid),
      .rsp_lightness(rsp_lightness), .rsp_green_red_axis(rsp_green_red_axis),
      .rsp_blue_yellow_axis(rsp_blue_yellow_axis)
   );

   oklab_checker scoreboard (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_red_linear(req_red_linear), .req_green_linear(req_green_linear),
      .req_blue_linear(req_blue_linear), .rsp_valid(rsp_valid),
      .rsp_lightness(rsp_lightness), .rsp_green_red_axis(rsp_green_red_axis),
      .rsp_blue_yellow_axis(rsp_blue_yellow_axis),
      .fail_count(fail_count), .pixels_in_flight(pixels_in_flight)
   );

   // Offers one pixel at the falling edge, after an optional idle gap, and
   // returns once it is taken. start stays high so back-to-back pixels
   // never drop it for a step.
   task automatic push_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                             int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start = 1'b0;
      end
      @(negedge clock);
      start = 1'b1;
      req_red_linear = r;
      req_green_linear = g;
      req_blue_linear = b;
      do @(posedge clock); while (busy);
   endtask

   // Mix of full range, dark tones, near white, single set bits and single cleared bits.
   function automatic logic [15:0] pick_component();
      case ($urandom_range(5))
         0, 1: return 16'($urandom_range(65535));
         2:    return 16'($urandom_range(255));
         3:    return 16'(65535 - $urandom_range(255));
         4:    return 16'(1) << $urandom_range(15);
         default: return ~(16'(1) << $urandom_range(15));
      endcase
   endfunction

   initial begin
      int idle_phase [4] = '{0, 60, 0, 37};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // black, white point (L saturates), primaries, secondaries, tiny values,
      // alternating bit patterns, mid grey, near white and a mixed pixel
      push_pixel(16'h0000, 16'h0000, 16'h0000, 0);
      push_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
      push_pixel(16'hFFFF, 16'h0000, 16'h0000, 0);
      push_pixel(16'h0000, 16'hFFFF, 16'h0000, 0);
      push_pixel(16'h0000, 16'h0000, 16'hFFFF, 0);
      push_pixel(16'hFFFF, 16'hFFFF, 16'h0000, 0);
      push_pixel(16'hFFFF, 16'h0000, 16'hFFFF, 0);
      push_pixel(16'h0000, 16'hFFFF, 16'hFFFF, 0);
      push_pixel(16'h0001, 16'h0001, 16'h0001, 0);
      push_pixel(16'h0001, 16'h0000, 16'h0000, 0);
      push_pixel(16'h0000, 16'h0000, 16'h0001, 0);
      push_pixel(16'h8000, 16'h8000, 16'h8000, 0);
      push_pixel(16'h5555, 16'hAAAA, 16'h5555, 0);
      push_pixel(16'hAAAA, 16'h5555, 16'hAAAA, 0);
      push_pixel(16'hFFFE, 16'hFFFF, 16'hFFFE, 0);
      push_pixel(16'h7FFF, 16'h0000, 16'hFFFF, 0);

      // random phases, each with the sender idle rate given for it in idle_phase
      foreach (idle_phase[p]) begin
         repeat (210)
            push_pixel(pick_component(), pick_component(), pick_component(), idle_phase[p]);
         if (p == 1) begin
            // drain the pipe fully before going on
            @(negedge clock);
            start = 1'b0;
            while (pixels_in_flight != 0) @(posedge clock);
         end
      end
      @(negedge clock);
      start = 1'b0;

      while (pixels_in_flight != 0) @(posedge clock);
      repeat (40) @(posedge clock);   // let the pipe run out, plus margin
      if (fail_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

   // run guard: ends the run well beyond the length of a correct one
   initial begin
      #200000;
      $display("testbench: errors");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/lrgbok_pkg.sv
rtl/core/lrgbok_norm.sv
rtl/core/lrgbok_cbrt.sv
rtl/core/lrgbok_lane.sv
rtl/core/lrgbok_merge.sv
rtl/core/linear_rgb_to_oklab.sv
tb/oklab_checker.sv
tb/testbench.sv
